// File: hdl/brlm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brlm_pkg
// Shared constants and types of the block RMS level meter.
// ----------------------------------------------------------------------------
package brlm_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned SumW   = 42;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegDryAttack  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDryRelease = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWetAttack  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWetRelease = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlendStep  = 3'd4;

  localparam logic [15:0] ResetDryAttack  = 16'd22938;
  localparam logic [15:0] ResetDryRelease = 16'd52429;
  localparam logic [15:0] ResetWetAttack  = 16'd7864;
  localparam logic [15:0] ResetWetRelease = 16'd60293;
  localparam logic [15:0] ResetBlendStep  = 16'd3932;

  localparam logic [16:0] OneQ14   = 17'd16384;
  localparam logic [15:0] Log10Q16 = 16'd19728;
  localparam logic [15:0] WKeep    = 16'd58982;
  localparam logic [15:0] WNew     = 16'd6554;
  localparam logic [15:0] ScaleMin = 16'd3277;
  localparam logic [15:0] ScaleMax = 16'd24576;

  // Datapath operations sequenced by the controller.
  typedef enum logic [4:0] {
    OpNone, OpDivInit, OpDivStep, OpSqrtInit, OpSqrtStep, OpLogInit, OpLogStep,
    OpLogFinish, OpFollow, OpPeak, OpAct, OpFrzInit, OpFrzStep, OpFrzClamp,
    OpBlend, OpInterp, OpScale, OpPeak2, OpFinish
  } op_e;

  typedef struct packed {
    op_e  op;
    logic chan;   // 0 dry, 1 wet
  } cmd_t;

  typedef struct packed {
    logic frz_edge;
    logic frz_on;
  } stat_t;

  // Rounded weighted blend: (a*wa + b*wb + half) >> 16.
  function automatic logic [15:0] blend16(input logic [15:0] a, input logic [16:0] wa,
                                          input logic [15:0] b, input logic [16:0] wb);
    logic [33:0] s;
    s = 34'(a) * 34'(wa) + 34'(b) * 34'(wb) + 34'd32768;
    return s[31:16];
  endfunction

endpackage
`default_nettype wire

// File: hdl/brlm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brlm_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface brlm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/brlm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brlm_ctrl
// Sequencer for the per-block level computation.
// ----------------------------------------------------------------------------
module brlm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           hold_i,
  input  brlm_pkg::stat_t     stat_i,
  output brlm_pkg::cmd_t      cmd_o,
  output logic                busy_o
);
  import brlm_pkg::*;

  typedef enum logic [4:0] {
    SIdle, SDivI, SDiv, SSqrtI, SSqrt, SLogI, SLog, SLogF, SFol, SPeak, SAct,
    SFrzI, SFrz, SFrzC, SBlend, SInterp, SScale, SPeak2, SWait, SFin
  } state_e;

  state_e     state_q;
  logic       chan_q;
  logic [5:0] cnt_q;

  // Iteration counts: 42 divide steps, 16 root steps, 14 log steps,
  // 31 freeze-divide steps. The result is written only once the output
  // register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      chan_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        SIdle:   if (start_i) begin state_q <= SDivI; chan_q <= 1'b0; end
        SDivI:   begin state_q <= SDiv; cnt_q <= 6'd41; end
        SDiv:    if (cnt_q == 6'd0) state_q <= SSqrtI; else cnt_q <= cnt_q - 6'd1;
        SSqrtI:  begin state_q <= SSqrt; cnt_q <= 6'd15; end
        SSqrt:   if (cnt_q == 6'd0) state_q <= SLogI; else cnt_q <= cnt_q - 6'd1;
        SLogI:   begin state_q <= SLog; cnt_q <= 6'd13; end
        SLog:    if (cnt_q == 6'd0) state_q <= SLogF; else cnt_q <= cnt_q - 6'd1;
        SLogF:   state_q <= SFol;
        SFol:    if (chan_q) state_q <= SPeak; else begin
                   chan_q <= 1'b1; state_q <= SDivI;
                 end
        SPeak:   state_q <= SAct;
        SAct:    if (!stat_i.frz_on) state_q <= SWait;
                 else if (stat_i.frz_edge) state_q <= SFrzI;
                 else state_q <= SBlend;
        SFrzI:   begin state_q <= SFrz; cnt_q <= 6'd30; end
        SFrz:    if (cnt_q == 6'd0) state_q <= SFrzC; else cnt_q <= cnt_q - 6'd1;
        SFrzC:   state_q <= SBlend;
        SBlend:  state_q <= SInterp;
        SInterp: state_q <= SScale;
        SScale:  state_q <= SPeak2;
        SPeak2:  state_q <= SWait;
        SWait:   if (!hold_i) state_q <= SFin;
        SFin:    state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.chan = chan_q;
    unique case (state_q)
      SDivI:   cmd_o.op = OpDivInit;
      SDiv:    cmd_o.op = OpDivStep;
      SSqrtI:  cmd_o.op = OpSqrtInit;
      SSqrt:   cmd_o.op = OpSqrtStep;
      SLogI:   cmd_o.op = OpLogInit;
      SLog:    cmd_o.op = OpLogStep;
      SLogF:   cmd_o.op = OpLogFinish;
      SFol:    cmd_o.op = OpFollow;
      SPeak:   cmd_o.op = OpPeak;
      SAct:    cmd_o.op = OpAct;
      SFrzI:   cmd_o.op = OpFrzInit;
      SFrz:    cmd_o.op = OpFrzStep;
      SFrzC:   cmd_o.op = OpFrzClamp;
      SBlend:  cmd_o.op = OpBlend;
      SInterp: cmd_o.op = OpInterp;
      SScale:  cmd_o.op = OpScale;
      SPeak2:  cmd_o.op = OpPeak2;
      SWait:   cmd_o.op = OpNone;
      SFin:    cmd_o.op = OpFinish;
      default: cmd_o.op = OpNone;
    endcase
  end

  assign busy_o = (state_q != SIdle);
endmodule
`default_nettype wire

// File: hdl/brlm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brlm_dp
// Accumulators, shared divide/root/log unit and envelope registers.
// ----------------------------------------------------------------------------
module brlm_dp #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_BLOCK   = 4096,
  parameter int unsigned HIST_W      = 7,
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire logic [SAMPLE_BITS-1:0] dry_i,
  input  wire logic [SAMPLE_BITS-1:0] wet_i,
  input  wire logic                   end_i,
  input  wire logic                   frz_i,
  output logic                        start_o,
  input  brlm_pkg::cmd_t              cmd_i,
  output brlm_pkg::stat_t             stat_o,
  input  wire logic [15:0]            dry_att_i,
  input  wire logic [15:0]            dry_rel_i,
  input  wire logic [15:0]            wet_att_i,
  input  wire logic [15:0]            wet_rel_i,
  input  wire logic [15:0]            step_i,
  output logic                        res_vld_o,
  output logic [15:0]                 dry_o,
  output logic [15:0]                 wet_o,
  output logic [15:0]                 peak_o,
  output logic [15:0]                 act_o,
  output logic [HIST_W-1:0]           slot_o
);
  import brlm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCK + 1);
  localparam logic [SumW:0] SumMax = {1'b0, {SumW{1'b1}}};

  // Normalize a sample to a Q0.30 square.
  function automatic logic [SumW-1:0] sq30(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS:0]     mag;
    logic [2*SAMPLE_BITS+1:0] sq;
    logic [SumW+16:0]         w;
    mag = raw[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
    sq  = (2*SAMPLE_BITS+2)'(mag) * (2*SAMPLE_BITS+2)'(mag);
    w   = (SumW+17)'(sq);
    if (2*SAMPLE_BITS >= 32) w = w >> (2*SAMPLE_BITS - 32);
    else w = w << (32 - 2*SAMPLE_BITS);
    return w[SumW-1:0];
  endfunction

  logic [SumW-1:0] dsum_q, wsum_q, bdsum_q, bwsum_q;
  logic [CntW-1:0] cnt_q, n_q;
  logic            frz_q, frz_prev_q;
  logic [15:0]     denv_q, wenv_q, peak_q, act_q, scale_q, blend_q, tail_q;
  logic [HIST_W-1:0] pos_q;

  // Shared iterative unit registers.
  logic [SumW-1:0] num_q, quo_q;
  logic [CntW:0]   rem_q;
  logic [31:0]     sv_q, sres_q, sbit_q;
  logic [30:0]     m_q;
  logic [4:0]      lg_q;
  logic [19:0]     lgf_q;
  logic [15:0]     lvl_q, sc_q, adj_q;
  logic [30:0]     fn_q, fq_q;
  logic [15:0]     frem_q;
  logic            res_q;

  // Accumulate squares and detect the block end.
  logic [CntW-1:0] n_next;
  logic            blk_end;
  logic [SumW:0]   dadd, wadd;
  assign n_next  = cnt_q + CntW'(1);
  assign blk_end = end_i || (n_next >= CntW'(MAX_BLOCK));
  assign dadd    = {1'b0, dsum_q} + {1'b0, sq30(dry_i)};
  assign wadd    = {1'b0, wsum_q} + {1'b0, sq30(wet_i)};
  assign start_o = acc_i && blk_end;

  assign stat_o.frz_on   = frz_q;
  assign stat_o.frz_edge = frz_q && !frz_prev_q;

  // Combinational helpers for one iteration step.
  logic [CntW:0]   rem_sh;
  logic [31:0]     sqr_t;
  logic [61:0]     msq;
  logic [30:0]     msh;
  logic [16:0]     frem_sh;
  logic [15:0]     att, rel, env;
  logic [15:0]     wdiv;
  logic [16:0]     blend_sum;
  logic [16:0]     dlt;
  logic [32:0]     iprod;
  logic [31:0]     sprod;
  logic [15:0]     mx;
  logic [17:0]     sc_calc;

  assign rem_sh  = {rem_q[CntW-1:0], num_q[SumW-1]};
  assign sqr_t   = sres_q + sbit_q;
  assign msq     = 62'(m_q) * 62'(m_q);
  assign msh     = msq[60:30];
  assign frem_sh = {frem_q, fn_q[30]};
  assign att     = cmd_i.chan ? wet_att_i : dry_att_i;
  assign rel     = cmd_i.chan ? wet_rel_i : dry_rel_i;
  assign env     = cmd_i.chan ? wenv_q : denv_q;
  assign wdiv    = (wenv_q == 16'd0) ? 16'd1 : wenv_q;
  assign blend_sum = {1'b0, blend_q} + {1'b0, step_i};
  assign dlt     = (scale_q <= OneQ14[15:0]) ? (OneQ14 - {1'b0, scale_q})
                                             : ({1'b0, scale_q} - OneQ14);
  assign iprod   = 33'(dlt) * 33'(blend_q) + 33'd32768;
  assign sprod   = 32'(wenv_q) * 32'(sc_q) + 32'd8192;
  assign mx      = (denv_q > wenv_q) ? denv_q : wenv_q;
  assign sc_calc = (scale_q <= OneQ14[15:0]) ? (18'(scale_q) + 18'(iprod[32:16]))
                                             : (18'(scale_q) - 18'(iprod[32:16]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsum_q <= '0; wsum_q <= '0; cnt_q <= '0;
      bdsum_q <= '0; bwsum_q <= '0; n_q <= '0;
      denv_q <= '0; wenv_q <= '0; peak_q <= '0; act_q <= '0;
      scale_q <= '0; blend_q <= '0; tail_q <= '0;
      frz_q <= 1'b0; frz_prev_q <= 1'b0; pos_q <= '0; res_q <= 1'b0;
      num_q <= '0; quo_q <= '0; rem_q <= '0;
      sv_q <= '0; sres_q <= '0; sbit_q <= '0;
      m_q <= '0; lg_q <= '0; lgf_q <= '0;
      lvl_q <= '0; sc_q <= '0; adj_q <= '0;
      fn_q <= '0; fq_q <= '0; frem_q <= '0;
      dry_o <= '0; wet_o <= '0; peak_o <= '0; act_o <= '0; slot_o <= '0;
    end else begin
      res_q <= 1'b0;
      if (acc_i) begin
        if (blk_end) begin
          bdsum_q <= (dadd > SumMax) ? SumMax[SumW-1:0] : dadd[SumW-1:0];
          bwsum_q <= (wadd > SumMax) ? SumMax[SumW-1:0] : wadd[SumW-1:0];
          n_q     <= n_next;
          frz_q   <= frz_i;
          dsum_q  <= '0; wsum_q <= '0; cnt_q <= '0;
        end else begin
          dsum_q <= (dadd > SumMax) ? SumMax[SumW-1:0] : dadd[SumW-1:0];
          wsum_q <= (wadd > SumMax) ? SumMax[SumW-1:0] : wadd[SumW-1:0];
          cnt_q  <= n_next;
        end
      end
      unique case (cmd_i.op)
        OpDivInit: begin
          num_q <= cmd_i.chan ? bwsum_q : bdsum_q;
          rem_q <= '0;
          quo_q <= '0;
        end
        // Restoring divide, one quotient bit a cycle.
        OpDivStep: begin
          num_q <= {num_q[SumW-2:0], 1'b0};
          if (rem_sh >= {1'b0, n_q}) begin
            rem_q <= rem_sh - {1'b0, n_q};
            quo_q <= {quo_q[SumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[SumW-2:0], 1'b0};
          end
        end
        OpSqrtInit: begin
          sv_q   <= (quo_q > SumW'(32'h4000_0000)) ? 32'h4000_0000 : quo_q[31:0];
          sres_q <= '0;
          sbit_q <= 32'h4000_0000;
        end
        // Digit-by-digit square root.
        OpSqrtStep: begin
          if (sv_q >= sqr_t) begin
            sv_q   <= sv_q - sqr_t;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
        // Normalize 32768 + 72*rms to [2^30, 2^31).
        OpLogInit: begin
          logic [22:0] y;
          y = 23'd32768 + 23'(sres_q[15:0]) * 23'd72;
          if (y[22])      begin m_q <= 31'(y) << 8; lg_q <= 5'd7; end
          else if (y[21]) begin m_q <= 31'(y) << 9; lg_q <= 5'd6; end
          else if (y[20]) begin m_q <= 31'(y) << 10; lg_q <= 5'd5; end
          else if (y[19]) begin m_q <= 31'(y) << 11; lg_q <= 5'd4; end
          else if (y[18]) begin m_q <= 31'(y) << 12; lg_q <= 5'd3; end
          else if (y[17]) begin m_q <= 31'(y) << 13; lg_q <= 5'd2; end
          else if (y[16]) begin m_q <= 31'(y) << 14; lg_q <= 5'd1; end
          else            begin m_q <= 31'(y) << 15; lg_q <= 5'd0; end
          lgf_q <= '0;
        end
        // One fraction bit by squaring.
        OpLogStep: begin
          if (msq[61]) begin
            m_q   <= msq[61:31];
            lgf_q <= {lgf_q[18:0], 1'b1};
          end else begin
            m_q   <= msh;
            lgf_q <= {lgf_q[18:0], 1'b0};
          end
        end
        OpLogFinish: begin
          logic [36:0] p;
          p = 37'({lg_q, lgf_q[13:0]}) * 37'(Log10Q16) + 37'd32768;
          lvl_q <= p[31:16];
        end
        // Attack/release envelope.
        OpFollow: begin
          logic [15:0] e;
          if (lvl_q > env) e = blend16(env, 17'h10000 - 17'(att), lvl_q, 17'(att));
          else             e = blend16(env, 17'(rel), lvl_q, 17'h10000 - 17'(rel));
          if (cmd_i.chan) wenv_q <= e; else denv_q <= e;
        end
        OpPeak: peak_q <= blend16(peak_q, 17'(WKeep), wenv_q, 17'(WNew));
        OpAct:  act_q  <= blend16(act_q, 17'(WKeep), mx, 17'(WNew));
        OpFrzInit: begin
          fn_q   <= 31'((tail_q == 16'd0) ? 16'd1 : tail_q) << 14;
          frem_q <= '0;
          fq_q   <= '0;
        end
        OpFrzStep: begin
          fn_q <= {fn_q[29:0], 1'b0};
          if (frem_sh >= {1'b0, wdiv}) begin
            frem_q <= 16'(frem_sh - {1'b0, wdiv});
            fq_q   <= {fq_q[29:0], 1'b1};
          end else begin
            frem_q <= frem_sh[15:0];
            fq_q   <= {fq_q[29:0], 1'b0};
          end
        end
        OpFrzClamp: begin
          if (fq_q < 31'(ScaleMin)) scale_q <= ScaleMin;
          else if (fq_q > 31'(ScaleMax)) scale_q <= ScaleMax;
          else scale_q <= fq_q[15:0];
          blend_q <= '0;
        end
        OpBlend: begin
          blend_q <= blend_sum[16] ? 16'hFFFF : blend_sum[15:0];
        end
        OpInterp: sc_q <= sc_calc[15:0];
        OpScale:  adj_q <= (sprod[31:14] > 18'hFFFF) ? 16'hFFFF : sprod[29:14];
        OpPeak2:  peak_q <= blend16(peak_q, 17'(WKeep), adj_q, 17'(WNew));
        OpFinish: begin
          dry_o  <= frz_q ? 16'd0 : denv_q;
          wet_o  <= frz_q ? adj_q : wenv_q;
          tail_q <= frz_q ? adj_q : wenv_q;
          peak_o <= peak_q;
          act_o  <= act_q;
          slot_o <= pos_q;
          pos_q  <= (pos_q == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + HIST_W'(1);
          frz_prev_q <= frz_q;
          res_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_vld_o = res_q;
endmodule
`default_nettype wire

// File: hdl/block_rms_level_meter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_rms_level_meter_top
// Block RMS level meter with attack/release and freeze scaling.
// ----------------------------------------------------------------------------
// Usage: sample pairs enter on in_ch, one word per cycle while a block is
// being summed. The word flagged block_end (or the one that fills MAX_BLOCK
// pairs) starts the per-block computation: per channel a 42-step restoring
// divide, a 16-step root and a 14-step log by squaring, then the envelope
// updates, and on the rising edge of freeze a 31-step scale divide. in_ch is
// not ready after the end word until the result is written (longer in freeze,
// longest on the freeze edge); the result word is then offered on out_ch.
// One result word per block is held in an output register until taken.
// While it waits, sample words are still taken; a following block is
// computed but held before its result is written, and in_ch stays not ready
// until the waiting word leaves.
// Configuration writes on cfg_ch are always accepted; unknown indexes are
// ignored. Reset clears all sums, envelopes and the history position and
// loads the coefficient defaults.
// ----------------------------------------------------------------------------
module block_rms_level_meter_top #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_BLOCK     = 4096,
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  brlm_if.sink     in_ch,
  brlm_if.source   out_ch,
  brlm_if.sink     cfg_ch
);
  import brlm_pkg::*;

  localparam int unsigned HistW = 7;

  logic [15:0] dry_att_q, dry_rel_q, wet_att_q, wet_rel_q, step_q;

  // Register writes.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_att_q <= ResetDryAttack; dry_rel_q <= ResetDryRelease;
      wet_att_q <= ResetWetAttack; wet_rel_q <= ResetWetRelease;
      step_q    <= ResetBlendStep;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        RegDryAttack:  dry_att_q <= cfg_ch.data.value;
        RegDryRelease: dry_rel_q <= cfg_ch.data.value;
        RegWetAttack:  wet_att_q <= cfg_ch.data.value;
        RegWetRelease: wet_rel_q <= cfg_ch.data.value;
        RegBlendStep:  step_q    <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;
  logic  busy, start, acc, res_vld, out_vld_q;
  logic [15:0] dry_l, wet_l, peak_l, act_l;
  logic [HistW-1:0] slot;

  // Hold off the input while a block is computed.
  assign in_ch.ready = !busy;
  assign acc = in_ch.valid && in_ch.ready;

  brlm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .hold_i(out_vld_q), .stat_i(stat),
    .cmd_o(cmd), .busy_o(busy)
  );

  brlm_dp #(
    .SAMPLE_BITS(SAMPLE_BITS), .MAX_BLOCK(MAX_BLOCK), .HIST_W(HistW),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .acc_i(acc),
    .dry_i(in_ch.data.dry_sample), .wet_i(in_ch.data.wet_sample),
    .end_i(in_ch.data.block_end), .frz_i(in_ch.data.freeze_mode),
    .start_o(start), .cmd_i(cmd), .stat_o(stat),
    .dry_att_i(dry_att_q), .dry_rel_i(dry_rel_q), .wet_att_i(wet_att_q),
    .wet_rel_i(wet_rel_q), .step_i(step_q), .res_vld_o(res_vld),
    .dry_o(dry_l), .wet_o(wet_l), .peak_o(peak_l), .act_o(act_l), .slot_o(slot)
  );

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (res_vld) out_vld_q <= 1'b1;
    else if (out_ch.ready) out_vld_q <= 1'b0;
  end

  assign out_ch.valid               = out_vld_q;
  assign out_ch.data.dry_level      = dry_l;
  assign out_ch.data.wet_level      = wet_l;
  assign out_ch.data.tail_level     = wet_l;
  assign out_ch.data.peak_level     = peak_l;
  assign out_ch.data.activity_level = act_l;
  assign out_ch.data.history_slot   = slot;
endmodule
`default_nettype wire
